### rtl/tkq_pkg.sv
// Package: item types, mode codes and sequencer states for the top-k position query block.
package tkq_pkg;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic [8:0]         k_count;
      logic [8:0]         p_position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] answer;
      logic               error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LATCH,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

endpackage

### rtl/tkq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/topk_in_order_position_query.sv
// Top level: order-preserving top-k position query over a store of signed values.
//
// Items arrive on req_ (valid/ready) as a req_type: mode, value, k_count, p_position.
// Append (mode 0) writes value at the end of the store, no result;
// when the store already holds MAX_ENTRIES values, one error result is given instead.
// Clear (mode 2) sets the count to zero, no result. Mode 3 is ignored.
// Query (mode 1) checks k in 1..count and p in 1..k; out of range gives one error
// result (answer zero). Otherwise every stored value is ranked
// against every other by one shared signed comparator reading the store through
// one RAM read port: each candidate row is fetched, latched, scanned against every
// stored value and decided, rows walked in position order until the p-th chosen
// value is found.
// req_ready is high only while no item is in work. Results leave through an output
// register on rsp_ (valid/ready) as a rsp_type; a finished result waits there while
// the next item is taken, and the sequencer holds its result if that register is
// still occupied. Reset empties the store count and drops any pending result; the
// stored values themselves are not cleared.
module topk_in_order_position_query
   import tkq_pkg::*;
#(
   parameter int MAX_ENTRIES = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = (CW > 9) ? CW : 9;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      jd_ff, jd_in;
   logic               dv_ff, dv_in;
   logic [CW-1:0]      rank_ff, rank_in;
   logic [CW-1:0]      seen_ff, seen_in;
   logic signed [31:0] vi_ff, vi_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      p_ff, p_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               full;
   logic               query_bad;
   logic [KW-1:0]      req_k, req_p;
   logic               ram_we;
   logic [AW-1:0]      ram_raddr;
   logic signed [31:0] ram_rdata;
   logic               beats;
   logic               chosen;
   logic [CW-1:0]      seen_nx;
   logic               hit;
   logic               last_row;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(MAX_ENTRIES));
   assign req_k     = KW'(req_data.k_count);
   assign req_p     = KW'(req_data.p_position);
   assign query_bad = (req_k == '0) || (req_k > KW'(count_ff)) ||
                      (req_p == '0) || (req_p > req_k);

   assign beats    = (ram_rdata > vi_ff) || ((ram_rdata == vi_ff) && (jd_ff < i_ff));
   assign chosen   = KW'(rank_ff) < k_ff;
   assign seen_nx  = seen_ff + CW'(1);
   assign hit      = chosen && (KW'(seen_nx) == p_ff);
   assign last_row = ((i_ff + CW'(1)) == count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign ram_we    = accept && (req_data.mode == MODE_APPEND) && !full;
   assign ram_raddr = (state_ff == ST_FETCH) ? i_ff[AW-1:0] : j_ff[AW-1:0];

   tkq_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_data.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_APPEND: state_in = full ? ST_EMIT : ST_IDLE;
                  MODE_QUERY:  state_in = query_bad ? ST_EMIT : ST_FETCH;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH:  state_in = ST_LATCH;
         ST_LATCH:  state_in = ST_SCAN;
         ST_SCAN: begin
            if ((j_ff == count_ff) && !dv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: state_in = (hit || last_row) ? ST_EMIT : ST_FETCH;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      dv_in        = 1'b0;
      rank_in      = rank_ff;
      seen_in      = seen_ff;
      vi_in        = vi_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in    = req_k;
               p_in    = req_p;
               i_in    = '0;
               seen_in = '0;
               res_in  = '{answer: '0, error: 1'b1};
               unique case (req_data.mode)
                  MODE_APPEND: begin
                     if (!full) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_CLEAR:  count_in = '0;
                  default:     count_in = count_ff;
               endcase
            end
         end
         ST_FETCH: begin
         end
         ST_LATCH: begin
            vi_in   = ram_rdata;
            rank_in = '0;
            j_in    = '0;
         end
         ST_SCAN: begin
            if (j_ff != count_ff) begin
               j_in  = j_ff + CW'(1);
               jd_in = j_ff;
               dv_in = 1'b1;
            end
            if (dv_ff && beats) begin
               rank_in = rank_ff + CW'(1);
            end
         end
         ST_DECIDE: begin
            if (chosen) begin
               seen_in = seen_nx;
            end
            if (hit) begin
               res_in = '{answer: vi_ff, error: 1'b0};
            end
            i_in = i_ff + CW'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      jd_ff       <= jd_in;
      rank_ff     <= rank_in;
      seen_ff     <= seen_in;
      vi_ff       <= vi_in;
      k_ff        <= k_in;
      p_ff        <= p_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("store count above capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff <= count_ff))
      else $error("scan index past stored count");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_LATCH || state_ff == ST_SCAN ||
       state_ff == ST_DECIDE) |-> (i_ff < count_ff))
      else $error("candidate row past stored count");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (rank_ff < count_ff))
      else $error("rank reached stored count");

   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not handed to output register");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the order-preserving top-k position query block.
module testbench;
   import tkq_pkg::*;

   localparam int unsigned ENTRIES      = 256;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned QUIET_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 100;
   localparam logic [1:0]  MODE_IGNORED = 2'd3;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_items[$];
   rsp_type expected_answers[$];

   logic signed [31:0] shadow_values [ENTRIES];
   int unsigned        shadow_count = 0;

   int unsigned plan_count = 0;
   int unsigned items_queued = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned quiet_cycles = 0;
   int unsigned failures = 0;
   bit          sender_gaps_on = 1'b1;
   bit          receiver_stalls_on = 1'b1;

   topk_in_order_position_query #(.MAX_ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 10) return 0;
      if (roll < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Updates the shadow store and queues the result the block must give.
   task automatic track_item(input req_type item);
      rsp_type     outcome;
      int unsigned k, p, rank, seen;
      bit          found;
      outcome.answer = '0;
      outcome.error  = 1'b1;
      k = item.k_count;
      p = item.p_position;
      case (item.mode)
         MODE_APPEND: begin
            if (shadow_count < ENTRIES) begin
               shadow_values[shadow_count] = item.value;
               shadow_count++;
            end else begin
               expected_answers.push_back(outcome);
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         MODE_QUERY: begin
            if (k >= 1 && k <= shadow_count && p >= 1 && p <= k) begin
               seen  = 0;
               found = 1'b0;
               for (int i = 0; i < shadow_count && !found; i++) begin
                  rank = 0;
                  for (int j = 0; j < shadow_count; j++) begin
                     if (shadow_values[j] > shadow_values[i] ||
                         (shadow_values[j] == shadow_values[i] && j < i))
                        rank++;
                  end
                  if (rank < k) begin
                     seen++;
                     if (seen == p) begin
                        outcome.answer = shadow_values[i];
                        outcome.error  = 1'b0;
                        found = 1'b1;
                     end
                  end
               end
            end
            expected_answers.push_back(outcome);
         end
         default: ;
      endcase
   endtask

   task automatic push_item(input logic [1:0] mode, input logic [31:0] value,
                            input int unsigned k, input int unsigned p);
      req_type item;
      item.mode       = mode;
      item.value      = value;
      item.k_count    = k[8:0];
      item.p_position = p[8:0];
      pending_items.push_back(item);
      if (mode == MODE_APPEND && plan_count < ENTRIES) plan_count++;
      if (mode == MODE_CLEAR) plan_count = 0;
      if (mode != MODE_IGNORED) items_queued++;
   endtask

   task automatic push_valid_query();
      int unsigned k;
      k = $urandom_range(1, plan_count);
      push_item(MODE_QUERY, $urandom, k, $urandom_range(1, k));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_answers.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_gap  <= sender_gaps_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) track_item(req_data);
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin : receive
      rsp_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_left   <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected item: answer %0d error %0b", rsp_data.answer,
                      rsp_data.error);
               failures++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_data.answer !== want.answer) begin
                  $error("answer: expected %0d, got %0d", want.answer, rsp_data.answer);
                  failures++;
               end
               if (rsp_data.error !== want.error) begin
                  $error("error: expected %0b, got %0b", want.error, rsp_data.error);
                  failures++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            stall_left   <= HOLD_CYCLES;
            rsp_ready    <= 1'b0;
         end else if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("topk_in_order_position_query verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned n;
      bit          narrow;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, field extremes, range errors, ties, ignored mode, clear
      push_item(MODE_QUERY, 0, 1, 1);
      push_item(MODE_APPEND, 32'h7FFF_FFFF, 0, 0);
      push_item(MODE_APPEND, 32'h8000_0000, 0, 0);
      push_item(MODE_APPEND, 32'h0000_0000, 0, 0);
      push_item(MODE_APPEND, 32'hFFFF_FFFF, 0, 0);
      push_item(MODE_APPEND, 32'd5, 0, 0);
      push_item(MODE_APPEND, 32'd5, 0, 0);
      push_item(MODE_QUERY, 0, 0, 1);
      push_item(MODE_QUERY, 0, 7, 1);
      push_item(MODE_QUERY, 0, 3, 0);
      push_item(MODE_QUERY, 0, 3, 4);
      push_item(MODE_QUERY, 0, 6, 1);
      push_item(MODE_QUERY, 32'hFFFF_FFFF, 6, 6);
      push_item(MODE_QUERY, 0, 511, 511);
      push_item(MODE_IGNORED, 32'hA5A5_A5A5, 341, 170);
      push_item(MODE_CLEAR, 0, 0, 0);
      push_item(MODE_QUERY, 0, 1, 1);
      push_item(MODE_APPEND, 32'd3, 0, 0);
      push_item(MODE_APPEND, 32'd9, 0, 0);
      push_item(MODE_APPEND, 32'd3, 0, 0);
      push_item(MODE_APPEND, 32'd1, 0, 0);
      push_item(MODE_APPEND, 32'd3, 0, 0);
      push_item(MODE_QUERY, 0, 2, 1);
      push_item(MODE_QUERY, 0, 2, 2);
      push_item(MODE_QUERY, 0, 1, 1);
      wait_drained();

      // random: mostly append runs followed by valid queries, some noise
      items_queued = 0;
      while (items_queued < RANDOM_ITEMS) begin
         sender_gaps_on     = $urandom_range(0, 3) != 0;
         receiver_stalls_on = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 3) != 0) begin
            if (plan_count > 24 || $urandom_range(0, 2) == 0)
               push_item(MODE_CLEAR, $urandom, $urandom_range(0, 511),
                         $urandom_range(0, 511));
            n      = $urandom_range(1, 8);
            narrow = $urandom_range(0, 1);
            repeat (n)
               push_item(MODE_APPEND, narrow ? $urandom_range(0, 6) - 3 : $urandom,
                         $urandom_range(0, 511), $urandom_range(0, 511));
            repeat ($urandom_range(1, 4)) push_valid_query();
         end else begin
            repeat ($urandom_range(1, 4))
               push_item(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 511),
                         $urandom_range(0, 511));
            if (plan_count != 0)
               push_item(MODE_QUERY, 0, plan_count + $urandom_range(0, 1),
                         $urandom_range(0, 1) ? 0 : plan_count + 1);
         end
      end
      wait_drained();

      // long receiver hold while the sender keeps offering
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      hold_requests++;
      while (holds_served != hold_requests) @(posedge clock);
      push_item(MODE_CLEAR, 0, 0, 0);
      repeat (4) push_item(MODE_APPEND, $urandom, 0, 0);
      repeat (6) push_item(MODE_QUERY, 0, 0, 0);
      repeat (4) push_valid_query();
      wait_drained();

      // full store, append when full, largest queries
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      push_item(MODE_CLEAR, 0, 0, 0);
      repeat (ENTRIES)
         push_item(MODE_APPEND, $urandom_range(0, 1) ? $urandom_range(0, 15) - 8 : $urandom,
                   0, 0);
      push_item(MODE_APPEND, 32'h7FFF_FFFF, 0, 0);
      push_item(MODE_APPEND, $urandom, 0, 0);
      push_item(MODE_QUERY, 0, ENTRIES, ENTRIES);
      push_item(MODE_QUERY, 0, 1, 1);
      push_item(MODE_QUERY, 0, 200, $urandom_range(1, 200));
      push_item(MODE_QUERY, 0, ENTRIES + 1, 1);
      push_item(MODE_QUERY, 0, ENTRIES, 0);
      push_item(MODE_CLEAR, 0, 0, 0);
      push_item(MODE_QUERY, 0, 1, 1);
      wait_drained();

      repeat (50) @(posedge clock);
      if (failures == 0 && expected_answers.size() == 0)
         $display("topk_in_order_position_query verification clean");
      else
         $display("topk_in_order_position_query verification failed");
      $finish;
   end

endmodule
